// ===== design/qrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, product indexes and helpers for the quaternion to rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int PROD_W     = 32;
  localparam int MAG_W      = 31;
  localparam int NORM_W     = 33;
  localparam int REM_W      = 32;
  localparam int RECIP_W    = 63;
  localparam int DIV_STAGES = RECIP_W;
  localparam int RLO_W      = 32;
  localparam int RHI_W      = RECIP_W - RLO_W;
  localparam int PLO_W      = MAG_W + RLO_W;
  localparam int PHI_W      = MAG_W + RHI_W;
  localparam int FULL_W     = PHI_W + RLO_W;
  localparam int SHIFT      = 61 - FRAC_BITS;
  localparam int TERM_W     = FRAC_BITS + 3;
  localparam int ENTRY_W    = (FRAC_BITS + 5 > 18) ? FRAC_BITS + 5 : 18;
  localparam int NPROD      = 9;

  // product indexes
  localparam int P_XX = 0;
  localparam int P_XY = 1;
  localparam int P_XZ = 2;
  localparam int P_YY = 3;
  localparam int P_YZ = 4;
  localparam int P_ZZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;

  localparam logic signed [ENTRY_W-1:0] ONE = ENTRY_W'(1) << FRAC_BITS;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t prod_arr_t [NPROD];
  typedef logic signed [TERM_W-1:0] term_t;
  typedef term_t term_arr_t [NPROD];

  // clamp an entry to the 16-bit output range
  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [ENTRY_W-1:0] v);
    logic signed [ENTRY_W-1:0] hi;
    logic signed [ENTRY_W-1:0] lo;
    hi = ENTRY_W'(32767);
    lo = -ENTRY_W'(32768);
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[OUT_W-1:0];
    end
  endfunction

endpackage

// ===== design/qrm_sq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_sq
// Two stages: the ten pairwise products, then the norm (sum of squares).
// ----------------------------------------------------------------------------
module qrm_sq import qrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    v_in,
  input  logic signed [IN_W-1:0]  x,
  input  logic signed [IN_W-1:0]  y,
  input  logic signed [IN_W-1:0]  z,
  input  logic signed [IN_W-1:0]  w,
  output logic                    v_out,
  output prod_arr_t               prod,
  output logic [NORM_W-1:0]       norm
);

  logic      v1;
  prod_arr_t p1;
  prod_t     ww1;
  prod_t     xe, ye, ze, we;

  assign xe = PROD_W'(x);
  assign ye = PROD_W'(y);
  assign ze = PROD_W'(z);
  assign we = PROD_W'(w);

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1    <= v_in;
      v_out <= v1;
    end
  end

  // form the products
  always_ff @(posedge clk) begin
    if (en) begin
      p1[P_XX] <= xe * xe;
      p1[P_XY] <= xe * ye;
      p1[P_XZ] <= xe * ze;
      p1[P_YY] <= ye * ye;
      p1[P_YZ] <= ye * ze;
      p1[P_ZZ] <= ze * ze;
      p1[P_WX] <= we * xe;
      p1[P_WY] <= we * ye;
      p1[P_WZ] <= we * ze;
      ww1      <= we * we;
    end
  end

  // sum the squares, carry the products
  always_ff @(posedge clk) begin
    if (en) begin
      norm <= NORM_W'($unsigned(p1[P_XX])) + NORM_W'($unsigned(p1[P_YY]))
            + NORM_W'($unsigned(p1[P_ZZ])) + NORM_W'($unsigned(ww1));
      for (int i = 0; i < NPROD; i++) begin
        prod[i] <= p1[i];
      end
    end
  end

endmodule

// ===== design/qrm_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_recip
// Pipelined restoring divider, one quotient bit per stage: floor(2^62 / N).
// ----------------------------------------------------------------------------
module qrm_recip import qrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  logic [NORM_W-1:0]    norm,
  input  prod_arr_t            prod_in,
  output logic                 v_out,
  output logic [RECIP_W-1:0]   recip,
  output prod_arr_t            prod_out
);

  logic                v_s   [DIV_STAGES+1];
  logic [NORM_W-1:0]   n_s   [DIV_STAGES+1];
  logic [REM_W-1:0]    rem_s [DIV_STAGES+1];
  logic [RECIP_W-1:0]  q_s   [DIV_STAGES+1];
  prod_arr_t           p_s   [DIV_STAGES+1];

  assign v_s[0]   = v_in;
  assign n_s[0]   = norm;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign p_s[0]   = prod_in;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    // dividend is 2^62: its only set bit enters at the first stage
    localparam logic DBIT = (k == 0);
    logic [NORM_W-1:0] trial;
    logic [NORM_W-1:0] diff;
    logic              ge;

    assign trial = {rem_s[k], DBIT};
    assign ge    = (trial >= n_s[k]);
    assign diff  = trial - n_s[k];

    // advance the valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    // one subtract-and-compare step
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[k+1]   <= n_s[k];
        rem_s[k+1] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        q_s[k+1]   <= {q_s[k][RECIP_W-2:0], ge};
        p_s[k+1]   <= p_s[k];
      end
    end
  end

  assign v_out    = v_s[DIV_STAGES];
  assign recip    = q_s[DIV_STAGES];
  assign prod_out = p_s[DIV_STAGES];

  // remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v_s[DIV_STAGES] && n_s[DIV_STAGES] != '0) |->
      (NORM_W'(rem_s[DIV_STAGES]) < n_s[DIV_STAGES]))
    else $error("divider remainder not below divisor");

  // unit norm gives the full-scale reciprocal
  a_unit_norm: assert property (@(posedge clk) disable iff (rst)
    (v_s[DIV_STAGES] && n_s[DIV_STAGES] == NORM_W'(1)) |->
      (q_s[DIV_STAGES] == (RECIP_W'(1) << (RECIP_W - 1))))
    else $error("reciprocal of one is wrong");

  // frozen pipeline keeps its last stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v_s[DIV_STAGES]) && $stable(q_s[DIV_STAGES])))
    else $error("divider moved while held");

endmodule

// ===== design/qrm_term.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_term
// Scales each product by the reciprocal: two partial products, then combine,
// shift and restore the sign.
// ----------------------------------------------------------------------------
module qrm_term import qrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  logic [RECIP_W-1:0]   recip,
  input  prod_arr_t            prod,
  output logic                 v_out,
  output term_arr_t            term
);

  logic               v_a;
  logic               neg_a [NPROD];
  logic [PLO_W-1:0]   pp_lo [NPROD];
  logic [PHI_W-1:0]   pp_hi [NPROD];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a   <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v_a   <= v_in;
      v_out <= v_a;
    end
  end

  // split multiply of magnitude by reciprocal
  always_ff @(posedge clk) begin
    prod_t             pabs;
    logic [MAG_W-1:0]  mag;
    if (en) begin
      for (int i = 0; i < NPROD; i++) begin
        pabs     = prod[i][PROD_W-1] ? -prod[i] : prod[i];
        mag      = pabs[MAG_W-1:0];
        neg_a[i] <= prod[i][PROD_W-1];
        pp_lo[i] <= PLO_W'(mag) * PLO_W'(recip[RLO_W-1:0]);
        pp_hi[i] <= PHI_W'(mag) * PHI_W'(recip[RECIP_W-1:RLO_W]);
      end
    end
  end

  // combine, truncate and apply the sign
  always_ff @(posedge clk) begin
    logic [FULL_W-1:0]  full;
    logic [FULL_W-1:0]  sh;
    logic [TERM_W-2:0]  tmag;
    if (en) begin
      for (int i = 0; i < NPROD; i++) begin
        full = {pp_hi[i], {RLO_W{1'b0}}} + FULL_W'(pp_lo[i]);
        sh   = full >> SHIFT;
        tmag = sh[TERM_W-2:0];
        term[i] <= neg_a[i] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      end
    end
  end

endmodule

// ===== design/quaternion_to_rotation_matrix_top.sv =====
`timescale 1ns / 1ps
// Stages from input transaction to result: 2 product/norm, 63 divider,
//   2 scaling, 1 matrix/saturation output stage.
// Throughput: one transaction per cycle; the reciprocal divider is fully
//   pipelined one quotient bit per stage, and a stall freezes the whole pipe.
// Reset: synchronous rst clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Converts a Q2.14 quaternion into the nine Q2.14 entries of its 3x3 rotation
// matrix, saturated to 16 bits.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top import qrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  quat_x,
  input  logic signed [IN_W-1:0]  quat_y,
  input  logic signed [IN_W-1:0]  quat_z,
  input  logic signed [IN_W-1:0]  quat_w,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] r00,
  output logic signed [OUT_W-1:0] r01,
  output logic signed [OUT_W-1:0] r02,
  output logic signed [OUT_W-1:0] r10,
  output logic signed [OUT_W-1:0] r11,
  output logic signed [OUT_W-1:0] r12,
  output logic signed [OUT_W-1:0] r20,
  output logic signed [OUT_W-1:0] r21,
  output logic signed [OUT_W-1:0] r22
);

  logic                en;
  logic                v_sq, v_div, v_term;
  prod_arr_t           prod_sq, prod_div;
  logic [NORM_W-1:0]   norm;
  logic [RECIP_W-1:0]  recip;
  term_arr_t           term;

  // hold the whole pipe while a result waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  qrm_sq u_sq (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (in_valid),
    .x     (quat_x),
    .y     (quat_y),
    .z     (quat_z),
    .w     (quat_w),
    .v_out (v_sq),
    .prod  (prod_sq),
    .norm  (norm)
  );

  qrm_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (v_sq),
    .norm     (norm),
    .prod_in  (prod_sq),
    .v_out    (v_div),
    .recip    (recip),
    .prod_out (prod_div)
  );

  qrm_term u_term (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (v_div),
    .recip (recip),
    .prod  (prod_div),
    .v_out (v_term),
    .term  (term)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_term;
    end
  end

  // form the entries and saturate
  always_ff @(posedge clk) begin
    logic signed [ENTRY_W-1:0] xx, xy, xz, yy, yz, zz, wx, wy, wz;
    if (en) begin
      xx = ENTRY_W'(term[P_XX]);
      xy = ENTRY_W'(term[P_XY]);
      xz = ENTRY_W'(term[P_XZ]);
      yy = ENTRY_W'(term[P_YY]);
      yz = ENTRY_W'(term[P_YZ]);
      zz = ENTRY_W'(term[P_ZZ]);
      wx = ENTRY_W'(term[P_WX]);
      wy = ENTRY_W'(term[P_WY]);
      wz = ENTRY_W'(term[P_WZ]);
      r00 <= sat16(ONE - (yy + zz));
      r01 <= sat16(xy - wz);
      r02 <= sat16(xz + wy);
      r10 <= sat16(xy + wz);
      r11 <= sat16(ONE - (xx + zz));
      r12 <= sat16(yz - wx);
      r20 <= sat16(xz - wy);
      r21 <= sat16(yz + wx);
      r22 <= sat16(ONE - (xx + yy));
    end
  end

endmodule

// ===== verif/tb_quaternion_to_rotation_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_rotation_matrix_top
// Streams quaternions through the rotation matrix pipeline under random input
// bursts and output stalls, and checks each of the nine matrix entries against
// a behavioral predictor using exact integer arithmetic.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix_top;
  import qrm_pkg::*;

  typedef struct packed {
    logic signed [15:0] x, y, z, w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } rot_t;

  typedef struct {
    quat_t q;
    logic  has_rot;
    rot_t  rot;
  } quat_row_t;

  localparam int N_RANDOM = 1130;
  localparam int DRAIN    = 120;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  rot_t      rot_queue[$];
  quat_row_t quat_table[$];
  int        n_errors;
  int        n_checked;
  int        n_sent;
  int        n_saturated;

  quaternion_to_rotation_matrix_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clamp to the signed 16-bit range
  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Scaled product 2ab/N, truncated toward zero
  function automatic longint scaled_term(longint a, longint b, logic [63:0] recip);
    longint      p;
    logic [31:0] mag;
    logic [127:0] full;
    p    = a * b;
    mag  = (p < 0) ? 32'(-p) : 32'(p);
    full = (128'(mag) * 128'(recip)) >> (61 - FRAC_BITS);
    return (p < 0) ? -longint'(full[63:0]) : longint'(full[63:0]);
  endfunction

  function automatic rot_t predict_rotation(quat_t q);
    longint      x, y, z, w, one;
    logic [63:0] norm, recip;
    longint      xx, xy, xz, yy, yz, zz, wx, wy, wz;
    rot_t        m;
    x = q.x; y = q.y; z = q.z; w = q.w;
    norm  = 64'(x*x + y*y + z*z + w*w);
    recip = (norm == 0) ? 64'd0 : (64'd1 << 62) / norm;
    one   = longint'(1) << FRAC_BITS;
    xx = scaled_term(x, x, recip); xy = scaled_term(x, y, recip);
    xz = scaled_term(x, z, recip); yy = scaled_term(y, y, recip);
    yz = scaled_term(y, z, recip); zz = scaled_term(z, z, recip);
    wx = scaled_term(w, x, recip); wy = scaled_term(w, y, recip);
    wz = scaled_term(w, z, recip);
    m.m00 = clamp16(one - (yy + zz)); m.m01 = clamp16(xy - wz);
    m.m02 = clamp16(xz + wy);         m.m10 = clamp16(xy + wz);
    m.m11 = clamp16(one - (xx + zz)); m.m12 = clamp16(yz - wx);
    m.m20 = clamp16(xz - wy);         m.m21 = clamp16(yz + wx);
    m.m22 = clamp16(one - (xx + yy));
    return m;
  endfunction

  function automatic rot_t identity_rot();
    rot_t m;
    m = '0;
    m.m00 = 16'sd16384; m.m11 = 16'sd16384; m.m22 = 16'sd16384;
    return m;
  endfunction

  function automatic rot_t diag_rot(logic signed [15:0] a, logic signed [15:0] b,
                                    logic signed [15:0] c);
    rot_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  // Mostly unit-like quaternions, with some raw and tiny ones
  function automatic quat_t random_quat();
    quat_t q;
    int    sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      q.x = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.y = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.z = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.w = 16'($signed($urandom_range(0, 32768)) - 16384);
    end else if (sel < 8) begin
      q = quat_t'({$urandom, $urandom});
    end else begin
      q.x = 16'($signed($urandom_range(0, 16)) - 8);
      q.y = 16'($signed($urandom_range(0, 16)) - 8);
      q.z = 16'($signed($urandom_range(0, 16)) - 8);
      q.w = 16'($signed($urandom_range(0, 16)) - 8);
    end
    return q;
  endfunction

  task automatic send_quat(quat_t q);
    in_valid <= 1'b1;
    quat_x <= q.x; quat_y <= q.y; quat_z <= q.z; quat_w <= q.w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rot_queue.push_back(predict_rotation(q));
    n_sent++;
  endtask

  task automatic add_row(logic signed [15:0] x, logic signed [15:0] y,
                         logic signed [15:0] z, logic signed [15:0] w,
                         logic has_rot, rot_t rot);
    quat_row_t row;
    row.q = '{x, y, z, w};
    row.has_rot = has_rot;
    row.rot = rot;
    quat_table.push_back(row);
  endtask

  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    rot_t exp_rot, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (rot_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
      end else begin
        exp_rot = rot_queue.pop_front();
        n_checked++;
        if (got.m00 == 16'sh7fff || got.m00 == 16'sh8000) n_saturated++;
        for (int i = 0; i < 9; i++) begin
          if (got[143-16*i -: 16] !== exp_rot[143-16*i -: 16]) begin
            $display("%0t: entry %0d expected %0d actual %0d", $time, i,
                     $signed(exp_rot[143-16*i -: 16]), $signed(got[143-16*i -: 16]));
            n_errors++;
          end
        end
      end
    end
  end

  // Stall the output on a pattern: quiet spells and busy spells
  always @(posedge clk) begin
    int phase;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      phase = ($time / 400) % 3;
      if (phase == 0) out_stall <= 1'b0;
      else if (phase == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    n_errors = 0; n_checked = 0; n_sent = 0; n_saturated = 0;
    rst = 1'b1; in_valid = 1'b0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;

    // Directed rows: identity and axis-flip cases typed in, the rest predicted
    add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, identity_rot());
    add_row(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1, identity_rot());
    add_row(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1,
            diag_rot(16'sd16384, -16'sd16384, -16'sd16384));
    add_row(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b1,
            diag_rot(-16'sd16384, 16'sd16384, -16'sd16384));
    add_row(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b1,
            diag_rot(-16'sd16384, -16'sd16384, 16'sd16384));
    add_row(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b1, identity_rot());
    add_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0);
    add_row(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0);
    add_row(16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768, 1'b0, '0);
    add_row(16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0);
    add_row(16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, '0);
    add_row(16'sd1, -16'sd1, 16'sd1, 16'sd0, 1'b0, '0);
    add_row(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0, '0);
    add_row(-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 1'b0, '0);
    add_row(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, '0);
    add_row(16'sd0, -16'sd11585, 16'sd0, 16'sd11585, 1'b0, '0);
    add_row(16'sd3, 16'sd2, -16'sd1, 16'sd5, 1'b0, '0);
    add_row(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0);
    add_row(16'sh5555, -16'sh2aab, 16'sh1234, -16'sh0fed, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (quat_table[i]) begin
      send_quat(quat_table[i].q);
      if (quat_table[i].has_rot && quat_table[i].rot !== rot_queue[$]) begin
        $display("%0t: row %0d expected %h actual prediction %h", $time, i,
                 quat_table[i].rot, rot_queue[$]);
        n_errors++;
      end
    end
    in_valid <= 1'b0;

    // Pause until the pipe has drained completely
    while (rot_queue.size() != 0) @(posedge clk);

    // Random bursts with gaps
    for (int i = 0; i < N_RANDOM; i++) begin
      send_quat(random_quat());
      sender_gap();
    end
    in_valid <= 1'b0;

    while (rot_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d quaternions, checked %0d matrices (%0d with a clamped r00).",
             n_sent, n_checked, n_saturated);
    if (n_errors == 0 && rot_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
